/* rtl/core/rzs_pkg.sv */
// ----------------------------------------------------------------------------
// Rolling z-score package
// Constants and register indexes shared by the rolling z-score core.
// ----------------------------------------------------------------------------
package rzs_pkg;

  localparam int DEFAULT_WINDOW = 240;
  localparam int MIN_WINDOW     = 10;
  localparam int SIZE_CAP       = 2560;
  localparam int SIZE_BITS      = 12;
  localparam int THR_BITS       = 16;
  localparam int WLEN_BITS      = 9;
  localparam int PRICE_PORT_BITS = 24;
  localparam int MIN_SAMPLES    = 3;

  typedef enum logic [0:0] {
    CFG_WINDOW_LEN  = 1'b0,
    CFG_Z_THRESHOLD = 1'b1
  } cfg_index_t;

endpackage

/* rtl/core/rzs_ring.sv */
// ----------------------------------------------------------------------------
// Rolling z-score price ring
// Single-port-write, single-port-read price memory with registered read data.
// ----------------------------------------------------------------------------
module rzs_ring #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/rzs_mul.sv */
// ----------------------------------------------------------------------------
// Rolling z-score serial multiplier
// Shift-and-add multiplier that retires one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module rzs_mul #(
  parameter int AW = 66,
  parameter int BW = 33
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic             busy,
  output logic             done,
  output logic [AW+BW-1:0] p
);

  localparam int PW = AW + BW;
  localparam int CNTW = (BW > 1) ? $clog2(BW) : 1;

  logic [PW-1:0]   ash;
  logic [BW-1:0]   bsh;
  logic [CNTW-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        p    <= '0;
        ash  <= PW'(a);
        bsh  <= b;
        cnt  <= CNTW'(BW - 1);
      end else if (busy) begin
        if (bsh[0]) begin
          p <= p + ash;
        end
        ash <= ash << 1;
        bsh <= bsh >> 1;
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/core/rolling_zscore_threshold_flag_core.sv */
// ----------------------------------------------------------------------------
// Rolling z-score threshold flag core
// Flags prices whose z-score over a rolling window exceeds a threshold.
// ----------------------------------------------------------------------------
// One price is taken per transfer and written into a ring memory. The core
// then reads back the m newest prices, one per cycle, to form the window sum
// and sum of squares, and resolves the z-score test with a shared serial
// multiplier. An item ends early when the variance is zero or the threshold
// is not exceeded; otherwise the signal size is searched bit by bit. The
// result then waits for any previous result transfer to finish, and no new
// price is taken until the item is done. The first two prices after reset
// give no result. The ring needs no clearing after reset, and configuration
// writes are accepted in every cycle.
module rolling_zscore_threshold_flag_core #(
  parameter int WINDOW_MAX = 256,
  parameter int PRICE_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  rzs_pkg::cfg_index_t                 cfg_index,
  input  logic [15:0]                         cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [rzs_pkg::PRICE_PORT_BITS-1:0] close_price,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rzs_pkg::SIZE_BITS-1:0]       flag_size,
  output logic                                exceeded
);

  import rzs_pkg::*;

  localparam int AW = $clog2(WINDOW_MAX);
  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam int SW = PRICE_BITS + CW;
  localparam int QW = 2 * PRICE_BITS + CW;
  localparam int VW = 2 * SW;
  localparam int BW = (SW > 2 * THR_BITS) ? SW : 2 * THR_BITS;
  localparam int PW = VW + BW;
  localparam int KW = $clog2(SIZE_BITS);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_SWEEP   = 9'b000000010,
    S_MUL_MQ  = 9'b000000100,
    S_MUL_SS  = 9'b000001000,
    S_MUL_DSQ = 9'b000010000,
    S_MUL_RHS = 9'b000100000,
    S_MUL_A   = 9'b001000000,
    S_TRY     = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_t;

  state_t state;

  logic [WLEN_BITS-1:0]  window_len;
  logic [THR_BITS-1:0]   z_threshold;
  logic [CW-1:0]         samples_seen;
  logic [CW-1:0]         samples_next;
  logic [AW-1:0]         write_pointer;
  logic [31:0]           wl;
  logic [CW-1:0]         m_next;

  logic [CW-1:0]         m;
  logic [CW-1:0]         cnt;
  logic [AW-1:0]         rd_addr;
  logic                  rd_en;
  logic [PRICE_BITS-1:0] rd_data;
  logic [PRICE_BITS-1:0] x;
  logic [PRICE_BITS-1:0] price;
  logic                  rv1;
  logic                  rv2;
  logic [2*PRICE_BITS-1:0] sq;
  logic [SW-1:0]         window_sum;
  logic [QW-1:0]         window_sum_squares;
  logic [SW-1:0]         mx;
  logic [SW-1:0]         dev;
  logic [VW-1:0]         var_q;
  logic [VW-1:0]         dsq;
  logic [PW-1:0]         a_q;
  logic [SIZE_BITS-1:0]  s;
  logic [SIZE_BITS-1:0]  cand;
  logic [KW-1:0]         k;
  logic                  tmul;
  logic [SIZE_BITS-1:0]  res_size;
  logic                  res_exc;

  logic                  mul_start;
  logic [VW-1:0]         mul_a;
  logic [BW-1:0]         mul_b;
  logic                  mul_busy;
  logic                  mul_done;
  logic [PW-1:0]         mul_p;

  logic                  in_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign x         = close_price[PRICE_BITS-1:0];
  assign cand      = s | SIZE_BITS'(1 << k);

  always_comb begin
    samples_next = (samples_seen < CW'(WINDOW_MAX)) ? samples_seen + 1'b1 : samples_seen;
    wl = 32'(window_len);
    if (wl < 32'(MIN_WINDOW)) begin
      wl = 32'(DEFAULT_WINDOW);
    end
    if (wl > 32'(WINDOW_MAX)) begin
      wl = 32'(WINDOW_MAX);
    end
    m_next = (32'(samples_next) < wl) ? samples_next : CW'(wl);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len  <= WLEN_BITS'(DEFAULT_WINDOW);
      z_threshold <= THR_BITS'(384);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WINDOW_LEN:  window_len  <= cfg_data[WLEN_BITS-1:0];
        CFG_Z_THRESHOLD: z_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  rzs_ring #(
    .DEPTH(WINDOW_MAX),
    .WIDTH(PRICE_BITS)
  ) u_ring (
    .clk    (clk),
    .wr_en  (in_fire),
    .wr_addr(write_pointer),
    .wr_data(x),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  rzs_mul #(
    .AW(VW),
    .BW(BW)
  ) u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .busy (mul_busy),
    .done (mul_done),
    .p    (mul_p)
  );

  assign rd_en = (state == S_SWEEP) && (cnt < m);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      samples_seen  <= '0;
      write_pointer <= '0;
      out_valid     <= 1'b0;
      mul_start     <= 1'b0;
      rv1           <= 1'b0;
      rv2           <= 1'b0;
    end else begin
      mul_start <= 1'b0;
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            samples_seen  <= samples_next;
            write_pointer <= (32'(write_pointer) + 1 >= WINDOW_MAX) ? '0
                             : write_pointer + 1'b1;
            rd_addr       <= write_pointer;
            price         <= x;
            m             <= m_next;
            cnt           <= '0;
            window_sum    <= '0;
            window_sum_squares <= '0;
            rv1           <= 1'b0;
            rv2           <= 1'b0;
            if (32'(samples_next) >= MIN_SAMPLES) begin
              state <= S_SWEEP;
            end
          end
        end
        S_SWEEP: begin
          rv1 <= rd_en;
          rv2 <= rv1;
          if (rd_en) begin
            cnt     <= cnt + 1'b1;
            rd_addr <= (rd_addr == '0) ? AW'(WINDOW_MAX - 1) : rd_addr - 1'b1;
          end
          if (rv1) begin
            window_sum <= window_sum + SW'(rd_data);
            sq         <= rd_data * rd_data;
          end
          if (rv2) begin
            window_sum_squares <= window_sum_squares + QW'(sq);
          end
          if (!rd_en && !rv1 && !rv2) begin
            mx        <= SW'(m * price);
            mul_a     <= VW'(window_sum_squares);
            mul_b     <= BW'(m);
            mul_start <= 1'b1;
            state     <= S_MUL_MQ;
          end
        end
        S_MUL_MQ: begin
          if (mul_done) begin
            var_q     <= mul_p[VW-1:0];
            dev       <= (mx >= window_sum) ? mx - window_sum : window_sum - mx;
            mul_a     <= VW'(window_sum);
            mul_b     <= BW'(window_sum);
            mul_start <= 1'b1;
            state     <= S_MUL_SS;
          end
        end
        S_MUL_SS: begin
          if (mul_done) begin
            var_q <= var_q - mul_p[VW-1:0];
            if (var_q == mul_p[VW-1:0]) begin
              res_size <= '0;
              res_exc  <= 1'b0;
              state    <= S_DONE;
            end else begin
              mul_a     <= VW'(dev);
              mul_b     <= BW'(dev);
              mul_start <= 1'b1;
              state     <= S_MUL_DSQ;
            end
          end
        end
        S_MUL_DSQ: begin
          if (mul_done) begin
            dsq       <= mul_p[VW-1:0];
            mul_a     <= var_q;
            mul_b     <= BW'(z_threshold * z_threshold);
            mul_start <= 1'b1;
            state     <= S_MUL_RHS;
          end
        end
        S_MUL_RHS: begin
          if (mul_done) begin
            if ((PW'(dsq) << 16) > mul_p) begin
              res_exc   <= 1'b1;
              mul_a     <= dsq;
              mul_b     <= BW'(SIZE_CAP * SIZE_CAP);
              mul_start <= 1'b1;
              state     <= S_MUL_A;
            end else begin
              res_size <= '0;
              res_exc  <= 1'b0;
              state    <= S_DONE;
            end
          end
        end
        S_MUL_A: begin
          if (mul_done) begin
            a_q   <= mul_p;
            s     <= '0;
            k     <= KW'(SIZE_BITS - 1);
            tmul  <= 1'b0;
            state <= S_TRY;
          end
        end
        S_TRY: begin
          if (!tmul) begin
            if (32'(cand) <= SIZE_CAP) begin
              mul_a     <= var_q;
              mul_b     <= BW'(cand * cand);
              mul_start <= 1'b1;
              tmul      <= 1'b1;
            end else if (k == '0) begin
              res_size <= s;
              state    <= S_DONE;
            end else begin
              k <= k - 1'b1;
            end
          end else if (mul_done) begin
            tmul <= 1'b0;
            if (a_q >= mul_p) begin
              s <= cand;
            end
            if (k == '0) begin
              res_size <= (a_q >= mul_p) ? cand : s;
              state    <= S_DONE;
            end else begin
              k <= k - 1'b1;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            flag_size <= res_size;
            exceeded  <= res_exc;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_mul_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mul_busy)
    else $error("multiplier busy while core idle");

  a_size_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(flag_size) <= SIZE_CAP))
    else $error("flag size above cap");

  a_size_flag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !exceeded) |-> (flag_size == '0))
    else $error("nonzero size without threshold crossing");

  a_sweep_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) |-> (cnt <= m))
    else $error("sweep read past window");

endmodule
